[hdl/vpf_pkg.sv]
// Shared definitions for the video memory pixel fetch block.
// Holds field widths, mode, operation and register codes, and the
// command/status structs between controller and datapath. No dependencies.
package vpf_pkg;

  localparam int DEF_MEM_COLUMNS = 1024;
  localparam int DEF_MEM_ROWS    = 512;

  localparam int MODE_W     = 3;
  localparam int WIN_X_W    = 10;
  localparam int WIN_Y_W    = 9;
  localparam int COLUMN_W   = 11;
  localparam int ROW_W      = 9;
  localparam int HALF_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [MODE_W-1:0] MODE_GRAY4    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY8    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DIRECT15 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAL4     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PAL8     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PACKED24 = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_Y    = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_item;  // capture the accepted input item
    logic exec;       // write the halfword, or issue the first read
    logic second;     // capture first word, issue the dependent read
    logic load_out;   // load the decoded pixel into the output register
  } vpf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fetch;      // held item is a pixel fetch
    logic two_reads;  // current mode needs a second memory read
  } vpf_status_t;

endpackage

[hdl/vpf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module vpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/vpf_ctrl.sv]
// Sequencing controller for the video memory pixel fetch block.
// Depends on vpf_pkg for the command and status structs.
module vpf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  vpf_pkg::vpf_status_t st,
  output vpf_pkg::vpf_cmd_t    cmd
);
  import vpf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  always_comb begin
    slot_free     = !out_valid_r || !out_stall;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!st.fetch) begin
          state_nxt = S_IDLE;
        end else if (st.two_reads) begin
          state_nxt = S_SECOND;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SECOND: begin
        cmd.second = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/vpf_datapath.sv]
// Datapath of the video memory pixel fetch block: configuration registers,
// address generation, video memory, pixel decode and output register.
// Depends on vpf_pkg and vpf_ram.
module vpf_datapath #(
  parameter int MEM_COLUMNS = vpf_pkg::DEF_MEM_COLUMNS,
  parameter int MEM_ROWS    = vpf_pkg::DEF_MEM_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_operation,
  input  logic [vpf_pkg::COLUMN_W-1:0]    in_column,
  input  logic [vpf_pkg::ROW_W-1:0]       in_row,
  input  logic [vpf_pkg::HALF_W-1:0]      in_write_data,
  output logic [vpf_pkg::CHAN_W-1:0]      out_red,
  output logic [vpf_pkg::CHAN_W-1:0]      out_green,
  output logic [vpf_pkg::CHAN_W-1:0]      out_blue,
  input  vpf_pkg::vpf_cmd_t               cmd,
  output vpf_pkg::vpf_status_t            st
);
  import vpf_pkg::*;

  localparam int WORDS = MEM_COLUMNS * MEM_ROWS;
  localparam int AW    = $clog2(WORDS);
  localparam int AW1   = AW + 1;
  localparam int FULLW = $clog2(WORDS + 1024 * MEM_COLUMNS + 8192);
  localparam logic [HALF_W-1:0] INV15_MASK = 16'h8FFF;

  // value mod 3 by folding base-4 digits (4 = 1 mod 3)
  function automatic logic [1:0] mod3(input logic [WIN_X_W-1:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[9:8]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // configuration registers
  logic [MODE_W-1:0]  mode_r;
  logic [WIN_X_W-1:0] win_x_r;
  logic [WIN_Y_W-1:0] win_y_r;
  logic               invert_r;
  logic [WIN_X_W-1:0] pal_x_r;
  logic [WIN_Y_W-1:0] pal_y_r;

  // palette base (py*cols + px) mod words, two register stages
  logic [WIN_X_W-1:0] pal_rx_r, pal_rx_nxt;
  logic [WIN_X_W:0]   pal_row_r, pal_row_nxt;
  logic [AW-1:0]      pal_base_r, pal_base_nxt;
  logic [12:0]        px_work;
  logic [2:0]         px_quot;
  logic [11:0]        row_work;

  // held item
  logic               op_r;
  logic [COLUMN_W-1:0] column_r;
  logic [ROW_W-1:0]   row_r;
  logic [HALF_W-1:0]  wdata_r;

  // per-fetch flags and addresses
  logic               rng_ok_r, h0_ok_r, h1_ok_r, odd_r;
  logic [AW-1:0]      addr_r;
  logic [HALF_W-1:0]  hold_r;

  // address generation
  logic [WIN_X_W:0]   rowsum;
  logic [1:0]         wx_mod3;
  logic [1:0]         pk_phase;
  logic [12:0]        pk_byte;
  logic [11:0]        hw_in_row;
  logic [WIN_X_W:0]   mul_row;
  logic [11:0]        mul_col;
  logic [FULLW-1:0]   full_addr;
  logic               rng_ok, h0_ok, h1_ok, wr_ok;
  logic               is_pk;

  // memory
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [HALF_W-1:0]  rd_data;

  // decode
  logic [HALF_W-1:0]  data_w;
  logic [7:0]         byte_g4, byte_g8;
  logic [3:0]         nib, nib_g;
  logic [7:0]         pal_idx;
  logic [AW:0]        psum;
  logic [AW-1:0]      pal_addr;
  logic [HALF_W-1:0]  v15;
  logic [7:0]         g8;
  logic [7:0]         pb0, pb1, pb2;
  logic [23:0]        v24;
  logic [CHAN_W-1:0]  red_nxt, green_nxt, blue_nxt;
  logic [CHAN_W-1:0]  red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      win_x_r  <= '0;
      win_y_r  <= '0;
      invert_r <= 1'b0;
      pal_x_r  <= '0;
      pal_y_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MODE:     mode_r   <= cfg_data[MODE_W-1:0];
        CFG_WINDOW_X: win_x_r  <= cfg_data[WIN_X_W-1:0];
        CFG_WINDOW_Y: win_y_r  <= cfg_data[WIN_Y_W-1:0];
        CFG_INVERT:   invert_r <= cfg_data[0];
        CFG_PAL_X:    pal_x_r  <= cfg_data[WIN_X_W-1:0];
        CFG_PAL_Y:    pal_y_r  <= cfg_data[WIN_Y_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    px_work = 13'(pal_x_r);
    px_quot = '0;
    for (int i = 0; i < 4; i++) begin
      if (px_work >= 13'(MEM_COLUMNS)) begin
        px_work = px_work - 13'(MEM_COLUMNS);
        px_quot = px_quot + 3'd1;
      end
    end
    pal_rx_nxt  = px_work[WIN_X_W-1:0];
    pal_row_nxt = (WIN_X_W+1)'(pal_y_r) + (WIN_X_W+1)'(px_quot);
    row_work = 12'(pal_row_r);
    for (int i = 0; i < 4; i++) begin
      if (row_work >= 12'(MEM_ROWS)) begin
        row_work = row_work - 12'(MEM_ROWS);
      end
    end
    pal_base_nxt = AW'(FULLW'(row_work) * FULLW'(MEM_COLUMNS) + FULLW'(pal_rx_r));
  end

  always_ff @(posedge clk) begin
    pal_rx_r   <= pal_rx_nxt;
    pal_row_r  <= pal_row_nxt;
    pal_base_r <= pal_base_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r     <= in_operation;
      column_r <= in_column;
      row_r    <= in_row;
      wdata_r  <= in_write_data;
    end
  end

  assign st.fetch     = (op_r == OP_FETCH);
  assign st.two_reads = mode_r inside {MODE_PAL4, MODE_PAL8, MODE_PACKED24};

  always_comb begin
    is_pk  = (mode_r == MODE_PACKED24);
    rowsum = (WIN_X_W+1)'(win_y_r) + (WIN_X_W+1)'(row_r);
    if (mode_r inside {MODE_GRAY4, MODE_PAL4}) begin
      hw_in_row = 12'(win_x_r) + 12'(column_r[COLUMN_W-1:2]);
    end else if (mode_r inside {MODE_GRAY8, MODE_PAL8}) begin
      hw_in_row = 12'(win_x_r) + 12'(column_r[COLUMN_W-1:1]);
    end else begin
      hw_in_row = 12'(win_x_r) + 12'(column_r);
    end
    wx_mod3 = mod3(win_x_r);
    case (wx_mod3)
      2'd0:    pk_phase = 2'd3;
      2'd1:    pk_phase = 2'd1;
      default: pk_phase = 2'd2;
    endcase
    pk_byte = 13'({win_x_r, 1'b0}) + 13'(pk_phase) + 13'(column_r)
            + 13'({column_r, 1'b0});
    if (op_r == OP_FETCH) begin
      mul_row = rowsum;
      mul_col = is_pk ? pk_byte[12:1] : hw_in_row;
    end else begin
      mul_row = (WIN_X_W+1)'(row_r);
      mul_col = 12'(column_r);
    end
    full_addr = FULLW'(mul_row) * FULLW'(MEM_COLUMNS) + FULLW'(mul_col);
    rng_ok = (13'(hw_in_row) < 13'(MEM_COLUMNS)) && (12'(rowsum) < 12'(MEM_ROWS));
    h0_ok  = full_addr < FULLW'(WORDS);
    h1_ok  = (full_addr + FULLW'(1)) < FULLW'(WORDS);
    wr_ok  = (13'(column_r) < 13'(MEM_COLUMNS)) && (12'(row_r) < 12'(MEM_ROWS));
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rng_ok_r <= rng_ok;
      h0_ok_r  <= h0_ok;
      h1_ok_r  <= h1_ok;
      odd_r    <= pk_byte[0];
      addr_r   <= full_addr[AW-1:0];
    end
    if (cmd.second) begin
      hold_r <= rd_data;
    end
  end

  // index extraction from the first word, shared by second read and decode
  always_comb begin
    data_w  = rng_ok_r ? rd_data : '0;
    byte_g4 = column_r[1] ? data_w[15:8] : data_w[7:0];
    nib     = column_r[0] ? byte_g4[7:4] : byte_g4[3:0];
    byte_g8 = column_r[0] ? data_w[15:8] : data_w[7:0];
    if (mode_r == MODE_PAL4) begin
      pal_idx = {4'h0, invert_r ? ~nib : nib};
    end else begin
      pal_idx = invert_r ? ~byte_g8 : byte_g8;
    end
    psum = {1'b0, pal_base_r} + AW1'(pal_idx);
    if (psum >= AW1'(WORDS)) begin
      pal_addr = AW'(psum - AW1'(WORDS));
    end else begin
      pal_addr = psum[AW-1:0];
    end
  end

  assign mem_we    = cmd.exec && (op_r == OP_WRITE) && wr_ok;
  assign mem_re    = (cmd.exec && (op_r == OP_FETCH)) || cmd.second;
  assign mem_raddr = cmd.second ? (is_pk ? AW'(addr_r + AW'(1)) : pal_addr)
                                : full_addr[AW-1:0];

  vpf_ram #(
    .WIDTH (HALF_W),
    .DEPTH (WORDS)
  ) u_vram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (full_addr[AW-1:0]),
    .wr_data (wdata_r),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    nib_g     = invert_r ? {nib[1:0], nib[3:2]} : nib;
    g8        = invert_r ? ~byte_g8 : byte_g8;
    v15       = invert_r ? (~data_w & INV15_MASK) : data_w;
    pb0       = !h0_ok_r ? 8'h00 : (odd_r ? hold_r[15:8] : hold_r[7:0]);
    if (odd_r) begin
      pb1 = h1_ok_r ? rd_data[7:0] : 8'h00;
      pb2 = h1_ok_r ? rd_data[15:8] : 8'h00;
    end else begin
      pb1 = h0_ok_r ? hold_r[15:8] : 8'h00;
      pb2 = h1_ok_r ? rd_data[7:0] : 8'h00;
    end
    v24 = {pb2, pb1, pb0};
    if (invert_r) v24 = ~v24;
    case (mode_r)
      MODE_GRAY4: begin
        red_nxt   = {nib_g, 4'h0};
        green_nxt = {nib_g, 4'h0};
        blue_nxt  = {nib_g, 4'h0};
      end
      MODE_GRAY8: begin
        red_nxt   = g8;
        green_nxt = g8;
        blue_nxt  = g8;
      end
      MODE_DIRECT15: begin
        red_nxt   = {v15[4:0], 3'b000};
        green_nxt = {v15[9:5], 3'b000};
        blue_nxt  = {v15[14:10], 3'b000};
      end
      MODE_PAL4, MODE_PAL8: begin
        red_nxt   = {rd_data[4:0], 3'b000};
        green_nxt = {rd_data[9:5], 3'b000};
        blue_nxt  = {rd_data[14:10], 3'b000};
      end
      MODE_PACKED24: begin
        red_nxt   = v24[7:0];
        green_nxt = v24[15:8];
        blue_nxt  = v24[23:16];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

[hdl/vram_pixel_fetch_clut_decode.sv]
// Video memory pixel fetch with palette (CLUT) decode: top level.
// Depends on vpf_pkg, vpf_ctrl and vpf_datapath (which holds vpf_ram).
//
// The block owns a MEM_COLUMNS x MEM_ROWS video memory of 16-bit halfwords.
// A write item (operation 0) stores write_data at (column, row); writes
// outside the memory are dropped and give no result. A fetch item
// (operation 1) returns one RGB888 pixel at (column, row) of the viewing
// window set by window_x/window_y, decoded per the mode register: 4-bit and
// 8-bit gray, 15-bit direct color, 4-bit and 8-bit palette lookup (palette
// at palette_x/palette_y in the same memory, address wrapping around the
// memory end), and 24-bit packed bytes. Fetches past the row end or the
// memory end read zero before any inversion; modes 6 and 7 return black.
// Memory contents are undefined until written; there is no clearing pass.
// Sequencing: the block works on one item at a time, serialized by the single
// registered read port of the memory. After acceptance, a write passes the
// execute state; a gray or direct-color fetch passes execute and finish; a
// palette or packed-24 fetch passes execute, second read and finish, since
// those need a second memory read (palette: the index word then the palette
// entry; packed-24: two adjacent halfwords). A new item is accepted while the
// previous pixel still sits in the output register; a fetch finishing while
// that register is stalled holds until it drains. Configuration writes are
// always ready and are meant for idle periods; the palette base follows
// palette_x and palette_y through the pal_rx/pal_row and pal_base registers.
module vram_pixel_fetch_clut_decode #(
  parameter int MEM_COLUMNS = vpf_pkg::DEF_MEM_COLUMNS,
  parameter int MEM_ROWS    = vpf_pkg::DEF_MEM_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [vpf_pkg::COLUMN_W-1:0]    in_column,
  input  logic [vpf_pkg::ROW_W-1:0]       in_row,
  input  logic [vpf_pkg::HALF_W-1:0]      in_write_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vpf_pkg::CHAN_W-1:0]      out_red,
  output logic [vpf_pkg::CHAN_W-1:0]      out_green,
  output logic [vpf_pkg::CHAN_W-1:0]      out_blue
);
  import vpf_pkg::*;

  vpf_cmd_t    cmd;
  vpf_status_t st;
  logic        cfg_wr;

  // Registers take a write in any cycle; a transfer completes on valid alone.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Controller: accept, execute, optional second read, deliver.
  vpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath: registers, address math, memory, decode, output register.
  vpf_datapath #(
    .MEM_COLUMNS (MEM_COLUMNS),
    .MEM_ROWS    (MEM_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_operation  (in_operation),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_write_data (in_write_data),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .cmd           (cmd),
    .st            (st)
  );

endmodule
